[hdl/hccs_pkg.sv]
// ---------------------------------------------------------------------------
// hccs_pkg: shared types and constants
// Slot table sizing, field widths and the beat and table-access structs
// for the hashed call counter.
// ---------------------------------------------------------------------------
package hccs_pkg;

    // Table geometry (SLOTS must be a power of two: the hash start slot
    // is taken from the low bits of the hash)
    localparam int SLOTS      = 32;
    localparam int MAX_PROBES = 8;
    localparam int IDX_W      = $clog2(SLOTS);
    localparam int PCNT_W     = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;

    // Field widths
    localparam int SLOT_W = 6;
    localparam int KEY_W  = 64;
    localparam int CNT_W  = 32;
    localparam int STR_W  = 20;
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    // Register map (word index)
    localparam logic REG_SAMPLE_STRIDE = 1'b0;

    // Input beat
    typedef struct packed {
        logic             mode;
        logic [KEY_W-1:0] call_key;
    } t_in;

    // Result beat
    typedef struct packed {
        logic [SLOT_W-1:0] slot_index;
        logic              sample_now;
        logic [CNT_W-1:0]  call_count;
        logic              last;
    } t_out;

    // One table entry
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] count;
        logic [STR_W-1:0] stride;
    } t_entry;

    // Table access request from the sequencer
    typedef struct packed {
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        t_entry           wr_data;
    } t_tbl_req;

endpackage

[hdl/hashed_call_counter_sampler.sv]
// ---------------------------------------------------------------------------
// hashed_call_counter_sampler: keyed call counter with stride sampling
//
// Input channel (i_in_valid / i_in_data / o_in_stall): one beat per event.
// mode 0 records a call by 64-bit key; mode 1 is a frame boundary.
// Output channel (o_out_valid / o_out_data / i_out_stall): a record gives
// one result beat; a frame boundary gives SLOTS+1 beats, slots in order and
// the overflow bucket last, with last set on the final beat.
// A record probes up to MAX_PROBES slots through the single slot-table
// read port, one probe per cycle, passes the overflow state when the run
// overflows or the key is zero, and then loads the output register.
// A frame boundary reads, clears by write-back and outputs each slot in
// turn, then gives the overflow beat.
// One item is worked on at a time; the next may be accepted while the last
// result still waits in the output register.
// When the receiver stalls, the output register holds its beat and the
// sequencer waits for it before loading the next.
// Reset empties the table, zeroes counts, stride counters and the stride
// register at once; no clearing pass is needed.
// sample_stride is written over the APB port at byte address 0.
// ---------------------------------------------------------------------------
module hashed_call_counter_sampler
    import hccs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              i_in_valid,
    input  t_in               i_in_data,
    output logic              o_in_stall,
    // output channel
    output logic              o_out_valid,
    output t_out              o_out_data,
    input  logic              i_out_stall,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [STR_W-1:0] r_stride;
    t_tbl_req         w_tbl_req;
    t_entry           w_tbl_rdata;

    // stride register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride <= '0;
        end else if (psel && penable && pwrite && (paddr[2] == REG_SAMPLE_STRIDE)) begin
            r_stride <= pwdata[STR_W-1:0];
        end
    end

    // register readback
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SAMPLE_STRIDE) ?
                    {{(APB_DW - STR_W){1'b0}}, r_stride} : '0;

    hccs_engine u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_sample_stride (r_stride),
        .i_in_valid      (i_in_valid),
        .i_in_data       (i_in_data),
        .o_in_stall      (o_in_stall),
        .o_out_valid     (o_out_valid),
        .o_out_data      (o_out_data),
        .i_out_stall     (i_out_stall),
        .o_tbl_req       (w_tbl_req),
        .i_tbl_rdata     (w_tbl_rdata)
    );

    hccs_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_tbl_req),
        .o_rdata (w_tbl_rdata)
    );

endmodule

[hdl/hccs_table.sv]
// ---------------------------------------------------------------------------
// hccs_table: slot table memory
// Single-port-write, single-read synchronous memory of slot entries with a
// registered read. Per-entry valid bits make unwritten entries read
// as all zero (empty key, zero count, zero stride counter).
// ---------------------------------------------------------------------------
module hccs_table
    import hccs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_tbl_req i_req,
    output t_entry   o_rdata
);

    t_entry           mem [SLOTS];
    logic [SLOTS-1:0] r_vld;
    t_entry           r_rdata;
    logic             r_rvld;

    // memory array: write and registered read
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
        r_rdata <= mem[i_req.rd_addr];
    end

    // valid bits, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_vld[i_req.wr_addr] <= 1'b1;
            end
            r_rvld <= r_vld[i_req.rd_addr];
        end
    end

    // entries never written read as reset value
    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

[hdl/hccs_engine.sv]
// ---------------------------------------------------------------------------
// hccs_engine: probe and dump sequencer
// Walks the linear probe run through the slot table one entry per cycle,
// updates count and stride counter of the chosen slot, keeps the overflow
// bucket, sweeps the table on a frame boundary and drives the output
// register.
// ---------------------------------------------------------------------------
module hccs_engine
    import hccs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [STR_W-1:0] i_sample_stride,
    // input channel
    input  logic             i_in_valid,
    input  t_in              i_in_data,
    output logic             o_in_stall,
    // output channel
    output logic             o_out_valid,
    output t_out             o_out_data,
    input  logic             i_out_stall,
    // table port
    output t_tbl_req         o_tbl_req,
    input  t_entry           i_tbl_rdata
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_OVF   = 3'd2;
    localparam logic [2:0] S_DRD   = 3'd3;
    localparam logic [2:0] S_DOUT  = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [IDX_W-1:0]  r_probe, n_probe;
    logic [PCNT_W-1:0] r_pcnt, n_pcnt;
    logic [IDX_W-1:0]  r_idx, n_idx;
    t_out              r_res, n_res;
    logic [CNT_W-1:0]  r_ovf_cnt, n_ovf_cnt;
    logic [STR_W-1:0]  r_ovf_str, n_ovf_str;
    logic              r_out_vld, n_out_vld;
    t_out              r_out, n_out;

    logic              w_accept;
    logic              w_out_free;
    logic [KEY_W-1:0]  w_hash;
    logic [IDX_W-1:0]  w_start;
    logic [IDX_W-1:0]  w_probe_nxt;
    logic              w_hit;
    logic [CNT_W-1:0]  w_slot_cnt;
    logic [STR_W:0]    w_slot_str;
    logic [CNT_W-1:0]  w_ovf_cnt;
    logic [STR_W:0]    w_ovf_str;

    // saturating increment of a count
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + CNT_W'(1);
    endfunction

    // stride counter step: {sample flag, next counter}
    function automatic logic [STR_W:0] stride_step(input logic [STR_W-1:0] cur,
                                                   input logic [STR_W-1:0] stride);
        logic [STR_W-1:0] c;
        c = cur + STR_W'(1);
        if (stride == '0) begin
            return {1'b0, cur};
        end
        if (c >= stride) begin
            return {1'b1, STR_W'(0)};
        end
        return {1'b0, c};
    endfunction

    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_out_free  = !r_out_vld || !i_out_stall;
    assign w_hash      = (i_in_data.call_key >> 4) ^ (i_in_data.call_key >> 9);
    assign w_start     = w_hash[IDX_W-1:0];
    assign w_probe_nxt = (r_probe == IDX_W'(SLOTS - 1)) ? '0 : r_probe + IDX_W'(1);

    // slot compare and update from the read data
    assign w_hit      = (i_tbl_rdata.key == r_key) || (i_tbl_rdata.key == '0);
    assign w_slot_cnt = sat_inc(i_tbl_rdata.count);
    assign w_slot_str = stride_step(i_tbl_rdata.stride, i_sample_stride);
    assign w_ovf_cnt  = sat_inc(r_ovf_cnt);
    assign w_ovf_str  = stride_step(r_ovf_str, i_sample_stride);

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_key     = r_key;
        n_probe   = r_probe;
        n_pcnt    = r_pcnt;
        n_idx     = r_idx;
        n_res     = r_res;
        n_ovf_cnt = r_ovf_cnt;
        n_ovf_str = r_ovf_str;
        n_out_vld = r_out_vld && i_out_stall;
        n_out     = r_out;

        o_tbl_req         = '0;
        o_tbl_req.rd_addr = r_probe;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_key = i_in_data.call_key;
                    if (i_in_data.mode) begin
                        n_idx   = '0;
                        n_state = S_DRD;
                    end else if (i_in_data.call_key == '0) begin
                        n_state = S_OVF;
                    end else begin
                        o_tbl_req.rd_addr = w_start;
                        n_probe = w_start;
                        n_pcnt  = '0;
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (w_hit) begin
                    o_tbl_req.wr_en          = 1'b1;
                    o_tbl_req.wr_addr        = r_probe;
                    o_tbl_req.wr_data.key    = r_key;
                    o_tbl_req.wr_data.count  = w_slot_cnt;
                    o_tbl_req.wr_data.stride = w_slot_str[STR_W-1:0];
                    n_res.slot_index = SLOT_W'(r_probe);
                    n_res.sample_now = w_slot_str[STR_W];
                    n_res.call_count = w_slot_cnt;
                    n_res.last       = 1'b1;
                    n_state          = S_EMIT;
                end else if (r_pcnt == PCNT_W'(MAX_PROBES - 1)) begin
                    n_state = S_OVF;
                end else begin
                    // next probe issued while this one resolves
                    o_tbl_req.rd_addr = w_probe_nxt;
                    n_probe = w_probe_nxt;
                    n_pcnt  = r_pcnt + PCNT_W'(1);
                end
            end
            S_OVF: begin
                n_ovf_cnt        = w_ovf_cnt;
                n_ovf_str        = w_ovf_str[STR_W-1:0];
                n_res.slot_index = SLOT_W'(SLOTS);
                n_res.sample_now = w_ovf_str[STR_W];
                n_res.call_count = w_ovf_cnt;
                n_res.last       = 1'b1;
                n_state          = S_EMIT;
            end
            S_DRD: begin
                o_tbl_req.rd_addr = r_idx;
                n_state = S_DOUT;
            end
            S_DOUT: begin
                // report the count, write it back cleared
                o_tbl_req.wr_en          = 1'b1;
                o_tbl_req.wr_addr        = r_idx;
                o_tbl_req.wr_data.key    = i_tbl_rdata.key;
                o_tbl_req.wr_data.count  = '0;
                o_tbl_req.wr_data.stride = i_tbl_rdata.stride;
                n_res.slot_index = SLOT_W'(r_idx);
                n_res.sample_now = 1'b0;
                n_res.call_count = i_tbl_rdata.count;
                n_res.last       = 1'b0;
                n_state          = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_vld = 1'b1;
                    n_out     = r_res;
                    if (r_res.last) begin
                        n_state = S_IDLE;
                    end else if (r_idx == IDX_W'(SLOTS - 1)) begin
                        // overflow bucket closes the dump
                        n_res.slot_index = SLOT_W'(SLOTS);
                        n_res.sample_now = 1'b0;
                        n_res.call_count = r_ovf_cnt;
                        n_res.last       = 1'b1;
                        n_ovf_cnt        = '0;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_DRD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and bucket registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_ovf_cnt <= '0;
            r_ovf_str <= '0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_ovf_cnt <= n_ovf_cnt;
            r_ovf_str <= n_ovf_str;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_probe <= n_probe;
        r_pcnt  <= n_pcnt;
        r_idx   <= n_idx;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

[hdl/hccs_chk.sv]
// ---------------------------------------------------------------------------
// hccs_chk: port-level checker
// Watches the top-level ports of the call counter and flags beats that
// break its ordering and field rules.
// ---------------------------------------------------------------------------
module hccs_chk
    import hccs_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input t_out              o_out_data,
    input logic              i_out_stall
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed under stall");

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // slot index never exceeds the overflow bucket
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.slot_index <= SLOT_W'(SLOTS))
        else $error("slot index out of range");

    // only single-beat record results can be sampled
    a_sample_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.sample_now |-> o_out_data.last)
        else $error("sample flag on a dump beat");

    // an accepted item blocks the input channel next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item accepted back to back");

endmodule

bind hashed_call_counter_sampler hccs_chk u_chk (.*);
